/* rtl/nfha_pkg.sv */
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared widths, header layout, memory port bundle and sequencer states for
// the next-fit heap allocator.
// ----------------------------------------------------------------------------
package nfha_pkg;

   localparam int HEAP_UNITS = 4096;
   localparam int AW         = $clog2(HEAP_UNITS);       // header store address
   localparam int NW         = $clog2(HEAP_UNITS + 1);   // node code incl. sentinel
   localparam int SW         = 13;                       // block size in granules
   localparam int CW         = $clog2(HEAP_UNITS + 3);   // walk counter
   localparam int WALK_LIMIT = HEAP_UNITS + 2;

   localparam logic [NW-1:0] SENT_NODE = NW'(HEAP_UNITS);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE   = 1'b0;
   localparam logic CSR_HEAP_LENGTH = 1'b1;

   typedef struct packed {
      logic [SW-1:0] size;
      logic [NW-1:0] link;
   } hdr_type;

   typedef struct packed {
      logic          we;
      logic [AW-1:0] addr;
      hdr_type       wdata;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_ROV,
      S_A_CHK,
      S_A_EVAL,
      S_A_TAIL,
      S_F_BLK,
      S_F_ROV,
      S_F_CHK,
      S_F_EVAL,
      S_F_MRGP,
      S_F_WPREV,
      S_FIN
   } state_type;

endpackage

/* rtl/next_fit_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_unit
// Next-fit allocator with address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
// One transaction at a time. The sequencer walks the free list one node at a
// time through the single port of the header store, reading a node in one
// state and evaluating it in the next; the result is handed off from S_FIN
// once the response register is free.
// After reset or any configuration write the sequencer first seeds the heap
// header before a request is taken.
module next_fit_heap_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [11:0] req_request_size,
   input  logic [29:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [29:0] rsp_address,
   output logic        rsp_failed,
   output logic [12:0] rsp_used_granules,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [28:0] csr_write_data
);
   import nfha_pkg::*;

   mem_req_type mem_req;
   hdr_type     rd_data;

   nfha_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_request_size  (req_request_size),
      .req_block_address (req_block_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_address       (rsp_address),
      .rsp_failed        (rsp_failed),
      .rsp_used_granules (rsp_used_granules),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

   nfha_hdr_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

/* rtl/nfha_hdr_mem.sv */
// ----------------------------------------------------------------------------
// nfha_hdr_mem
// Single-port header store, one granule header per entry, registered read.
// ----------------------------------------------------------------------------
module nfha_hdr_mem (
   input  logic                 clock,
   input  nfha_pkg::mem_req_type mem_req,
   output nfha_pkg::hdr_type    rd_data
);
   import nfha_pkg::*;

   hdr_type mem_ff [HEAP_UNITS];
   hdr_type rd_ff;

   // write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      rd_ff <= mem_ff[mem_req.addr];
   end

   assign rd_data = rd_ff;

endmodule

/* rtl/nfha_seq.sv */
// ----------------------------------------------------------------------------
// nfha_seq
// List-walk sequencer: drives the header store one node per step, keeps the
// sentinel link, rover, used count and heap registers, and builds results.
// ----------------------------------------------------------------------------
module nfha_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [11:0]           req_request_size,
   input  logic [29:0]           req_block_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [29:0]           rsp_address,
   output logic                  rsp_failed,
   output logic [12:0]           rsp_used_granules,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [28:0]           csr_write_data,
   output nfha_pkg::mem_req_type mem_req,
   input  nfha_pkg::hdr_type     rd_data
);
   import nfha_pkg::*;

   state_type state_ff, state_in;
   logic [28:0]   base_ff;
   logic [12:0]   len_ff;
   logic          init_ff, init_in;
   logic [NW-1:0] sent_ff, sent_in;
   logic [NW-1:0] rover_ff, rover_in;
   logic [12:0]   used_ff, used_in;
   logic [SW-1:0] need_ff, need_in;
   logic [NW-1:0] blk_ff, blk_in;
   logic [SW-1:0] bsize_ff, bsize_in;
   logic [NW-1:0] prev_ff, prev_in;
   logic [SW-1:0] prev_sz_ff, prev_sz_in;
   logic [NW-1:0] p_ff, p_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] nd_ff, nd_in;
   logic [SW-1:0] blksz_ff, blksz_in;
   logic [NW-1:0] blklink_ff, blklink_in;
   logic [NW-1:0] tail_ff, tail_in;
   logic [29:0]   res_addr_ff, res_addr_in;
   logic          res_fail_ff, res_fail_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [29:0]   rsp_addr_ff;
   logic          rsp_fail_ff;
   logic [12:0]   rsp_used_ff;
   logic          rsp_load;

   logic [SW-1:0] eff_len;
   logic [SW-1:0] nsize;
   logic [NW-1:0] nlink;
   logic [29:0]   free_off;
   logic          free_ok;
   logic [NW:0]   rank_prev, rank_blk, rank_p;
   logic [31:0]   got;

   assign eff_len = (32'(len_ff) > HEAP_UNITS) ? SW'(HEAP_UNITS) : len_ff;

   // decode the node read issued last cycle
   assign nsize = (32'(nd_ff) < HEAP_UNITS) ? rd_data.size : '0;
   assign nlink = (nd_ff == SENT_NODE) ? sent_ff :
                  ((32'(nd_ff) < HEAP_UNITS) ? rd_data.link : SENT_NODE);

   assign free_off = req_block_address - 30'(base_ff) - 30'd1;
   assign free_ok  = (req_block_address > 30'(base_ff)) && (free_off < 30'(eff_len));

   // address ranks: the sentinel is lowest
   assign rank_prev = (prev_ff == SENT_NODE) ? '0 : ({1'b0, prev_ff} + 1'b1);
   assign rank_blk  = (blk_ff == SENT_NODE) ? '0 : ({1'b0, blk_ff} + 1'b1);
   assign rank_p    = (p_ff == SENT_NODE) ? '0 : ({1'b0, p_ff} + 1'b1);

   assign got = 32'(p_ff) + 32'(nsize) - 32'(need_ff);

   // hold state, registers and heap setup
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         len_ff       <= 13'd4096;
         init_ff      <= 1'b1;
         sent_ff      <= '0;
         rover_ff     <= SENT_NODE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_HEAP_BASE) begin
               base_ff <= csr_write_data;
            end else begin
               len_ff <= csr_write_data[12:0];
            end
            init_ff  <= 1'b1;
            sent_ff  <= '0;
            rover_ff <= SENT_NODE;
            used_ff  <= '0;
         end else begin
            init_ff  <= init_in;
            sent_ff  <= sent_in;
            rover_ff <= rover_in;
            used_ff  <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      need_ff     <= need_in;
      blk_ff      <= blk_in;
      bsize_ff    <= bsize_in;
      prev_ff     <= prev_in;
      prev_sz_ff  <= prev_sz_in;
      p_ff        <= p_in;
      cnt_ff      <= cnt_in;
      nd_ff       <= nd_in;
      blksz_ff    <= blksz_in;
      blklink_ff  <= blklink_in;
      tail_ff     <= tail_in;
      res_addr_ff <= res_addr_in;
      res_fail_ff <= res_fail_in;
      if (rsp_load) begin
         rsp_addr_ff <= res_addr_ff;
         rsp_fail_ff <= res_fail_ff;
         rsp_used_ff <= used_ff;
      end
   end

   // sequence one transaction over the free list
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      sent_in      = sent_ff;
      rover_in     = rover_ff;
      used_in      = used_ff;
      need_in      = need_ff;
      blk_in       = blk_ff;
      bsize_in     = bsize_ff;
      prev_in      = prev_ff;
      prev_sz_in   = prev_sz_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      nd_in        = nd_ff;
      blksz_in     = blksz_ff;
      blklink_in   = blklink_ff;
      tail_in      = tail_ff;
      res_addr_in  = res_addr_ff;
      res_fail_in  = res_fail_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_req      = '0;
      req_stall    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (init_ff) begin
               // seed one free block spanning the heap
               mem_req.we    = 1'b1;
               mem_req.addr  = '0;
               mem_req.wdata = '{size: eff_len, link: SENT_NODE};
               init_in       = 1'b0;
            end else begin
               req_stall   = 1'b0;
               res_addr_in = '0;
               res_fail_in = 1'b0;
               if (req_valid) begin
                  if (req_operation == OP_ALLOC) begin
                     need_in      = SW'({1'b0, req_request_size} + 13'd1);
                     mem_req.addr = rover_ff[AW-1:0];
                     nd_in        = rover_ff;
                     state_in     = S_A_ROV;
                  end else if (free_ok) begin
                     blk_in       = NW'(free_off);
                     mem_req.addr = free_off[AW-1:0];
                     nd_in        = NW'(free_off);
                     state_in     = S_F_BLK;
                  end else begin
                     state_in = S_FIN;
                  end
               end
            end
         end

         S_A_ROV: begin
            prev_in    = rover_ff;
            prev_sz_in = nsize;
            p_in       = nlink;
            cnt_in     = '0;
            state_in   = S_A_CHK;
         end

         S_A_CHK: begin
            if (32'(cnt_ff) == WALK_LIMIT || p_ff == rover_ff) begin
               res_fail_in = 1'b1;
               res_addr_in = '0;
               state_in    = S_FIN;
            end else begin
               mem_req.addr = p_ff[AW-1:0];
               nd_in        = p_ff;
               state_in     = S_A_EVAL;
            end
         end

         S_A_EVAL: begin
            if (nsize >= need_ff) begin
               rover_in = prev_ff;
               if ({1'b0, nsize} >= {need_ff, 1'b0}) begin
                  // cut the tail off and keep the front free
                  if (32'(p_ff) < HEAP_UNITS) begin
                     mem_req.we    = 1'b1;
                     mem_req.addr  = p_ff[AW-1:0];
                     mem_req.wdata = '{size: nsize - need_ff, link: nlink};
                  end
                  used_in     = used_ff + 13'(need_ff);
                  res_addr_in = 30'(32'(base_ff) + got + 32'd1);
                  tail_in     = NW'(got);
                  state_in    = (got < HEAP_UNITS) ? S_A_TAIL : S_FIN;
               end else begin
                  // unlink the whole block
                  if (prev_ff == SENT_NODE) begin
                     sent_in = nlink;
                  end else if (32'(prev_ff) < HEAP_UNITS) begin
                     mem_req.we    = 1'b1;
                     mem_req.addr  = prev_ff[AW-1:0];
                     mem_req.wdata = '{size: prev_sz_ff, link: nlink};
                  end
                  used_in     = used_ff + 13'(nsize);
                  res_addr_in = 30'(32'(base_ff) + 32'(p_ff) + 32'd1);
                  state_in    = S_FIN;
               end
            end else begin
               prev_in    = p_ff;
               prev_sz_in = nsize;
               p_in       = nlink;
               cnt_in     = cnt_ff + 1'b1;
               state_in   = S_A_CHK;
            end
         end

         S_A_TAIL: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = tail_ff[AW-1:0];
            mem_req.wdata = '{size: need_ff, link: '0};
            state_in      = S_FIN;
         end

         S_F_BLK: begin
            bsize_in     = nsize;
            mem_req.addr = rover_ff[AW-1:0];
            nd_in        = rover_ff;
            state_in     = S_F_ROV;
         end

         S_F_ROV: begin
            prev_in    = rover_ff;
            prev_sz_in = nsize;
            p_in       = nlink;
            cnt_in     = '0;
            state_in   = S_F_CHK;
         end

         S_F_CHK: begin
            if (32'(cnt_ff) == WALK_LIMIT) begin
               state_in = S_FIN;
            end else if (p_ff == rover_ff ||
                         (rank_prev < rank_blk && rank_blk < rank_p) ||
                         (rank_p <= rank_prev && rank_blk > rank_prev)) begin
               used_in = used_ff - 13'(bsize_ff);
               if (p_ff != SENT_NODE && (32'(blk_ff) + 32'(bsize_ff)) == 32'(p_ff)) begin
                  mem_req.addr = p_ff[AW-1:0];
                  nd_in        = p_ff;
                  state_in     = S_F_MRGP;
               end else begin
                  blksz_in      = bsize_ff;
                  blklink_in    = p_ff;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = blk_ff[AW-1:0];
                  mem_req.wdata = '{size: bsize_ff, link: p_ff};
                  state_in      = S_F_WPREV;
               end
            end else begin
               mem_req.addr = p_ff[AW-1:0];
               nd_in        = p_ff;
               state_in     = S_F_EVAL;
            end
         end

         S_F_EVAL: begin
            prev_in    = p_ff;
            prev_sz_in = nsize;
            p_in       = nlink;
            cnt_in     = cnt_ff + 1'b1;
            state_in   = S_F_CHK;
         end

         S_F_MRGP: begin
            // absorb the following free block
            blksz_in      = bsize_ff + nsize;
            blklink_in    = nlink;
            mem_req.we    = 1'b1;
            mem_req.addr  = blk_ff[AW-1:0];
            mem_req.wdata = '{size: bsize_ff + nsize, link: nlink};
            state_in      = S_F_WPREV;
         end

         S_F_WPREV: begin
            rover_in = prev_ff;
            if (prev_ff != SENT_NODE &&
                (32'(prev_ff) + 32'(prev_sz_ff)) == 32'(blk_ff)) begin
               // fold the block into the preceding one
               if (32'(prev_ff) < HEAP_UNITS) begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = prev_ff[AW-1:0];
                  mem_req.wdata = '{size: prev_sz_ff + blksz_ff, link: blklink_ff};
               end
            end else if (prev_ff == SENT_NODE) begin
               sent_in = blk_ff;
            end else if (32'(prev_ff) < HEAP_UNITS) begin
               mem_req.we    = 1'b1;
               mem_req.addr  = prev_ff[AW-1:0];
               mem_req.wdata = '{size: prev_sz_ff, link: blk_ff};
            end
            state_in = S_FIN;
         end

         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_address       = rsp_addr_ff;
   assign rsp_failed        = rsp_fail_ff;
   assign rsp_used_granules = rsp_used_ff;

endmodule

/* tb/sv/nfha_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfha_checker
// Watches the request, response and register ports of the next-fit heap
// allocator, keeps its own copy of the free list and compares every response,
// field by field, with the predicted one.
// ----------------------------------------------------------------------------
module nfha_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [11:0] req_request_size,
   input  logic [29:0] req_block_address,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [29:0] rsp_address,
   input  logic        rsp_failed,
   input  logic [12:0] rsp_used_granules,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [28:0] csr_write_data,
   output int          pending,
   output int          errors
);
   import nfha_pkg::*;

   typedef struct {
      bit [29:0] address;
      bit        failed;
      bit [12:0] used;
   } grant_type;

   grant_type   grant_queue[$];

   bit [12:0]   blk_size[HEAP_UNITS];
   bit [12:0]   blk_link[HEAP_UNITS];
   int unsigned head_link;
   int unsigned rover_node;
   int unsigned used_count;
   int unsigned base_reg;
   int unsigned length_reg;

   localparam int unsigned SENT  = HEAP_UNITS;
   localparam int unsigned WALKS = WALK_LIMIT;

   function automatic int unsigned heap_len();
      return (length_reg > HEAP_UNITS) ? HEAP_UNITS : length_reg;
   endfunction

   function automatic int unsigned size_of(int unsigned n);
      return (n < HEAP_UNITS) ? blk_size[n] : 0;
   endfunction

   function automatic int unsigned link_of(int unsigned n);
      if (n == SENT) return head_link;
      return (n < HEAP_UNITS) ? blk_link[n] : SENT;
   endfunction

   function automatic void put_size(int unsigned n, int unsigned v);
      if (n < HEAP_UNITS) blk_size[n] = v[12:0];
   endfunction

   function automatic void put_link(int unsigned n, int unsigned v);
      if (n == SENT) head_link = v;
      else if (n < HEAP_UNITS) blk_link[n] = v[12:0];
   endfunction

   // sentinel ranks below every block
   function automatic int unsigned order_of(int unsigned n);
      return (n == SENT) ? 0 : n + 1;
   endfunction

   function automatic void restart_heap();
      for (int i = 0; i < HEAP_UNITS; i++) begin
         blk_size[i] = '0;
         blk_link[i] = '0;
      end
      blk_size[0] = 13'(heap_len());
      blk_link[0] = 13'(SENT);
      head_link   = 0;
      rover_node  = SENT;
      used_count  = 0;
   endfunction

   // next-fit search from the rover; split the tail when the block is roomy
   function automatic bit carve_block(int unsigned req, output bit [29:0] addr);
      int unsigned need;
      int unsigned prev;
      int unsigned p;
      int unsigned s;
      int unsigned got;
      longint unsigned full;
      need = req + 1;
      prev = rover_node;
      p    = link_of(prev);
      addr = '0;
      for (int i = 0; i < WALKS; i++) begin
         if (p == rover_node) return 1'b0;
         s = size_of(p);
         if (s >= need) begin
            got = p;
            if (s >= 2 * need) begin
               put_size(p, s - need);
               got = p + s - need;
               put_size(got, need);
               used_count = (used_count + need) & 13'h1FFF;
            end else begin
               put_link(prev, link_of(p));
               used_count = (used_count + s) & 13'h1FFF;
            end
            rover_node = prev;
            full = longint'(base_reg) + got + 1;
            addr = full[29:0];
            return 1'b1;
         end
         prev = p;
         p    = link_of(p);
      end
      return 1'b0;
   endfunction

   // address-ordered insert with merging on both sides
   function automatic void release_block(bit [29:0] a);
      longint unsigned off;
      int unsigned blk;
      int unsigned bsize;
      int unsigned prev;
      int unsigned p;
      int unsigned rp;
      int unsigned rb;
      int unsigned rn;
      bit          found;
      if (longint'(a) < longint'(base_reg) + 1) return;
      off = longint'(a) - base_reg - 1;
      if (off >= heap_len()) return;
      blk   = 32'(off);
      bsize = size_of(blk);
      prev  = rover_node;
      p     = link_of(prev);
      found = 1'b0;
      for (int i = 0; i < WALKS; i++) begin
         rp = order_of(prev);
         rb = order_of(blk);
         rn = order_of(p);
         if (p == rover_node || (rp < rb && rb < rn) || (rn <= rp && rb > rp)) begin
            found = 1'b1;
            break;
         end
         prev = p;
         p    = link_of(p);
      end
      if (!found) return;
      used_count = (used_count - bsize) & 13'h1FFF;
      if (p != SENT && blk + bsize == p) begin
         put_link(blk, link_of(p));
         put_size(blk, bsize + size_of(p));
      end else begin
         put_link(blk, p);
      end
      if (prev != SENT && prev + size_of(prev) == blk) begin
         put_link(prev, link_of(blk));
         put_size(prev, size_of(prev) + size_of(blk));
      end else begin
         put_link(prev, blk);
      end
      rover_node = prev;
   endfunction

   function automatic int field_diff(string name, longint unsigned exp_v,
                                     longint unsigned act_v);
      if (exp_v == act_v) return 0;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      return 1;
   endfunction

   assign pending = grant_queue.size();

   always @(posedge clock) begin
      grant_type g;
      bit [29:0] a;
      if (reset) begin
         base_reg   = 0;
         length_reg = 4096;
         restart_heap();
         grant_queue.delete();
         errors = 0;
      end else begin
         // compare the response transaction first, it belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (grant_queue.size() == 0) begin
               $display("%0t ns: response with nothing expected, actual address %0d",
                        $time, rsp_address);
               errors = errors + 1;
            end else begin
               g = grant_queue.pop_front();
               errors = errors + field_diff("address", g.address, rsp_address)
                               + field_diff("failed", g.failed, rsp_failed)
                               + field_diff("used_granules", g.used, rsp_used_granules);
            end
         end
         // predict the accepted request
         if (req_valid && !req_stall) begin
            g.failed = 1'b0;
            g.address = '0;
            if (req_operation == OP_ALLOC) begin
               if (carve_block(req_request_size, a)) g.address = a;
               else g.failed = 1'b1;
            end else begin
               release_block(req_block_address);
            end
            g.used = used_count[12:0];
            grant_queue.push_back(g);
         end
         // any register write starts a new heap
         if (csr_write_enable) begin
            if (csr_index == CSR_HEAP_BASE) base_reg = 32'(csr_write_data);
            else length_reg = 32'(csr_write_data[12:0]);
            restart_heap();
         end
      end
   end

endmodule

/* tb/sv/tb_next_fit_heap_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_fit_heap_allocator_unit
// Drives allocate and free transactions into the heap allocator over several
// heap settings, with random idling and a long response hold-off; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_next_fit_heap_allocator_unit;
   import nfha_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [11:0] req_request_size;
   logic [29:0] req_block_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [29:0] rsp_address;
   logic        rsp_failed;
   logic [12:0] rsp_used_granules;
   logic        csr_write_enable;
   logic        csr_index;
   logic [28:0] csr_write_data;
   int          pending;
   int          errors;

   bit [29:0]   live_blocks[$];
   bit          calm;
   int          hold_asks;
   int          hold_done;
   int          hold_left;
   int          cycles;
   int          n_alloc;
   int          n_free;
   int          n_phase;

   next_fit_heap_allocator_unit dut (.*);

   nfha_checker u_checker (.*);

   // clock generator
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 12);
      end
   end

   // collect granted addresses for later frees
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && !rsp_failed && rsp_address != 0)
         live_blocks.push_back(rsp_address);
   end

   task automatic send_item(bit op, bit [11:0] size, bit [29:0] addr);
      if (!calm) begin
         while ($urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_request_size  <= size;
      req_block_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_ALLOC) n_alloc++;
      else n_free++;
   endtask

   task automatic alloc_item(bit [11:0] size);
      send_item(OP_ALLOC, size, 30'($urandom));
   endtask

   // free a live block, or a random stray address when none is known
   task automatic free_live();
      int k;
      bit [29:0] a;
      if (live_blocks.size() == 0) begin
         send_item(OP_FREE, 12'($urandom), 30'($urandom));
      end else begin
         k = $urandom_range(live_blocks.size() - 1);
         a = live_blocks[k];
         live_blocks.delete(k);
         send_item(OP_FREE, 12'($urandom), a);
      end
   endtask

   task automatic write_reg(logic idx, logic [28:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // drain, then start a new heap
   task automatic new_heap(bit [28:0] base, bit [12:0] len);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      live_blocks.delete();
      write_reg(CSR_HEAP_BASE, base);
      write_reg(CSR_HEAP_LENGTH, 29'(({$urandom} << 13) | 32'(len)));
      @(posedge clock);
      n_phase++;
   endtask

   task automatic random_items(int count, int max_size);
      int r;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 55) begin
            if ($urandom_range(9) == 0) alloc_item(12'($urandom));
            else alloc_item(12'($urandom_range(max_size)));
         end else if (r < 92) begin
            free_live();
         end else begin
            send_item(OP_FREE, 12'($urandom), 30'($urandom));
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_operation     <= OP_ALLOC;
      req_request_size  <= '0;
      req_block_address <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_HEAP_BASE;
      csr_write_data    <= '0;
      calm      = 1'b0;
      hold_asks = 0;
      n_alloc   = 0;
      n_free    = 0;
      n_phase   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full heap at base zero: extremes, split, unlink, merge, stray frees
      new_heap(29'd0, 13'd4096);
      alloc_item(12'd0);
      alloc_item(12'd4095);
      free_live();
      alloc_item(12'd4095);
      free_live();
      alloc_item(12'd10);
      alloc_item(12'd20);
      alloc_item(12'd30);
      free_live();
      free_live();
      free_live();
      send_item(OP_FREE, 12'hFFF, 30'd0);
      send_item(OP_FREE, 12'd0, 30'd4097);
      send_item(OP_FREE, 12'd0, 30'h3FFFFFFF);

      // top base with oversized length
      new_heap(29'h1FFFFFFF, 13'h1FFF);
      alloc_item(12'd100);
      send_item(OP_FREE, 12'd0, 30'd5);
      free_live();

      // empty heap: every allocation fails
      new_heap(29'($urandom), 13'd0);
      alloc_item(12'd0);
      alloc_item(12'hFFF);
      send_item(OP_FREE, 12'd0, 30'd1);

      // one granule heap
      new_heap(29'd7, 13'd1);
      alloc_item(12'd0);
      alloc_item(12'd0);
      free_live();
      alloc_item(12'd0);

      // random phases, one with no idling and one with a long hold-off
      new_heap(29'($urandom), 13'd300);
      random_items(70, 40);

      new_heap(29'($urandom), 13'd4096);
      calm = 1'b1;
      random_items(70, 200);
      calm = 1'b0;

      new_heap(29'($urandom), 13'd64);
      hold_asks = hold_asks + 1;
      random_items(70, 12);

      new_heap(29'($urandom), 13'($urandom_range(16, 4096)));
      random_items(70, 63);

      new_heap(29'h1FFFFFFF, 13'd2000);
      random_items(70, 100);

      new_heap(29'($urandom), 13'd150);
      random_items(60, 20);

      // drain and settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d heap settings, %0d allocates and %0d frees.",
               n_phase, n_alloc, n_free);
      if (errors == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
